// File: rtl/hamming_29_24_sec_codec_defines.svh
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef HAMMING_29_24_SEC_CODEC_DEFINES_SVH
`define HAMMING_29_24_SEC_CODEC_DEFINES_SVH

// same-cycle implication
`define HM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec package
// Check masks, action codes, stage payload types and the syndrome function.
// ---------------------------------------------------------------------------
package hm_pkg;

    localparam logic [31:0] CHK0_MASK = 32'h1555_5555;
    localparam logic [31:0] CHK1_MASK = 32'h0CCC_CCCC;
    localparam logic [31:0] CHK2_MASK = 32'h03C3_C3C3;
    localparam logic [31:0] CHK3_MASK = 32'h003F_C03F;
    localparam logic [31:0] CHK4_MASK = 32'h0000_3FFF;
    localparam logic [31:0] TOP_MASK  = 32'hE000_0000;
    localparam logic [4:0]  CODE_LEN  = 5'd29;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] word;
        logic [4:0]  syn;
        logic        erased;
    } t_chk;

    typedef struct packed {
        logic        action;
        logic [31:0] word;
        logic [4:0]  syn;
        logic        corrected;
        logic        uncorrectable;
        logic        erased;
    } t_fix;

    function automatic logic [4:0] calc_syndrome(input logic [31:0] w);
        calc_syndrome = {^(w & CHK4_MASK), ^(w & CHK3_MASK), ^(w & CHK2_MASK),
                         ^(w & CHK1_MASK), ^(w & CHK0_MASK)};
    endfunction

endpackage

// File: rtl/hm_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec channels
// Valid/ready interfaces for the request and result transactions.
// ---------------------------------------------------------------------------
interface hm_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  byte_hi;
    logic [7:0]  byte_mid;
    logic [7:0]  byte_lo;
    logic [31:0] stored_word;

    modport source (output valid, action, byte_hi, byte_mid, byte_lo, stored_word,
                    input ready);
    modport sink   (input valid, action, byte_hi, byte_mid, byte_lo, stored_word,
                    output ready);
endinterface

interface hm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_out;
    logic [7:0]  dec_hi;
    logic [7:0]  dec_mid;
    logic [7:0]  dec_lo;
    logic [4:0]  syndrome;
    logic        corrected;
    logic        uncorrectable;
    logic        erased;

    modport source (output valid, code_out, dec_hi, dec_mid, dec_lo, syndrome,
                    corrected, uncorrectable, erased, input ready);
    modport sink   (input valid, code_out, dec_hi, dec_mid, dec_lo, syndrome,
                    corrected, uncorrectable, erased, output ready);
endinterface

// File: rtl/hamming_29_24_sec_codec.sv
// Path: an accepted request is registered by the check, fix and output stages in turn before the result is valid.
// Throughput: one transaction per cycle while the result sink is ready; each stage advances when the next one is free.
// A stalled result holds in the output register while upstream stages keep filling.
// Reset (synchronous, active low) clears the three stage valid bits; no clearing pass.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec
// Encodes three bytes into a 29-bit Hamming code word or decodes and corrects
// a single-bit error in a stored word, three register stages deep.
// ---------------------------------------------------------------------------
`include "hamming_29_24_sec_codec_defines.svh"

module hamming_29_24_sec_codec (
    input  logic i_clk,
    input  logic i_rst_n,
    hm_in_if.sink    i_in,
    hm_out_if.source o_out
);
    import hm_pkg::*;

    logic chk_valid;
    t_chk chk_data;
    logic fix_ready;
    logic fix_valid;
    t_fix fix_data;
    logic out_ready;

    hm_chk_stage u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (fix_ready),
        .o_valid (chk_valid),
        .o_data  (chk_data)
    );

    hm_fix_stage u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chk_valid),
        .i_data  (chk_data),
        .o_ready (fix_ready),
        .i_ready (out_ready),
        .o_valid (fix_valid),
        .o_data  (fix_data)
    );

    hm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fix_valid),
        .i_data  (fix_data),
        .o_ready (out_ready),
        .o_out   (o_out)
    );

    `HM_ASSERT_NOW(a_code_top_zero, o_out.valid, o_out.code_out[31:29] == 3'd0, "code word top bits set")
    `HM_ASSERT_NOW(a_fix_excl, o_out.valid && o_out.corrected, !o_out.uncorrectable && o_out.code_out == '0 && o_out.syndrome != '0, "corrected result inconsistent")
    `HM_ASSERT_NOW(a_bad_syn, o_out.valid && o_out.uncorrectable, o_out.syndrome == 5'd30 || o_out.syndrome == 5'd31, "uncorrectable without out-of-range syndrome")
    `HM_ASSERT_NEXT(a_fix_hold, fix_valid && !out_ready, fix_valid && $stable(fix_data), "fix stage lost data while stalled")
endmodule

// File: rtl/hm_chk_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec - check stage
// Places data bits (encode) or takes the stored word (decode) and registers
// it with its 5-bit parity check.
// ---------------------------------------------------------------------------
module hm_chk_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hm_in_if.sink        i_in,
    input  logic         i_ready,
    output logic         o_valid,
    output hm_pkg::t_chk o_data
);
    import hm_pkg::*;

    logic        r_valid;
    t_chk        r_data;
    t_chk        n_data;
    logic [31:0] placed;
    logic        adv;

    assign adv        = !r_valid || i_ready;
    assign i_in.ready = adv;

    always_comb begin
        placed        = '0;
        placed[26]    = i_in.byte_hi[7];
        placed[24:22] = i_in.byte_hi[6:4];
        placed[20:17] = i_in.byte_hi[3:0];
        placed[16:14] = i_in.byte_mid[7:5];
        placed[12:8]  = i_in.byte_mid[4:0];
        placed[7:0]   = i_in.byte_lo;

        n_data.action = i_in.action;
        n_data.word   = (i_in.action == ACT_DECODE) ? i_in.stored_word : placed;
        n_data.syn    = calc_syndrome(n_data.word);
        n_data.erased = (i_in.action == ACT_DECODE) && ((i_in.stored_word & TOP_MASK) != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: rtl/hm_fix_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec - fix stage
// Inserts parity bits on encode; flips the addressed bit on decode, or flags an out-of-range syndrome as uncorrectable.
// ---------------------------------------------------------------------------
module hm_fix_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  hm_pkg::t_chk i_data,
    output logic         o_ready,
    input  logic         i_ready,
    output logic         o_valid,
    output hm_pkg::t_fix o_data
);
    import hm_pkg::*;

    logic        r_valid;
    t_fix        r_data;
    t_fix        n_data;
    logic [4:0]  pos;
    logic        in_range;
    logic        adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    assign pos      = CODE_LEN - i_data.syn;
    assign in_range = (i_data.syn != '0) && (i_data.syn <= CODE_LEN);

    always_comb begin
        n_data.action        = i_data.action;
        n_data.word          = i_data.word;
        n_data.syn           = i_data.syn;
        n_data.corrected     = 1'b0;
        n_data.uncorrectable = 1'b0;
        n_data.erased        = i_data.erased;
        if (i_data.action == ACT_ENCODE) begin
            n_data.word[28] = i_data.syn[0];
            n_data.word[27] = i_data.syn[1];
            n_data.word[25] = i_data.syn[2];
            n_data.word[21] = i_data.syn[3];
            n_data.word[13] = i_data.syn[4];
            n_data.syn      = '0;
        end else if (in_range) begin
            n_data.word      = i_data.word ^ (32'd1 << pos);
            n_data.corrected = 1'b1;
        end else if (i_data.syn != '0) begin
            n_data.uncorrectable = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: rtl/hm_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec - output stage
// Extracts the data bytes and holds the result transaction for the sink.
// ---------------------------------------------------------------------------
module hm_out_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  hm_pkg::t_fix i_data,
    output logic         o_ready,
    hm_out_if.source     o_out
);
    import hm_pkg::*;

    logic        r_valid;
    logic [31:0] r_code_out;
    logic [7:0]  r_dec_hi;
    logic [7:0]  r_dec_mid;
    logic [7:0]  r_dec_lo;
    logic [4:0]  r_syndrome;
    logic        r_corrected;
    logic        r_uncorrectable;
    logic        r_erased;
    logic        adv;
    logic        dec;

    assign adv     = !r_valid || o_out.ready;
    assign o_ready = adv;
    assign dec     = (i_data.action == ACT_DECODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_code_out      <= dec ? '0 : i_data.word;
            r_dec_hi        <= dec ? {i_data.word[26], i_data.word[24:22], i_data.word[20:17]}
                                   : '0;
            r_dec_mid       <= dec ? {i_data.word[16:14], i_data.word[12:8]} : '0;
            r_dec_lo        <= dec ? i_data.word[7:0] : '0;
            r_syndrome      <= i_data.syn;
            r_corrected     <= i_data.corrected;
            r_uncorrectable <= i_data.uncorrectable;
            r_erased        <= i_data.erased;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.code_out      = r_code_out;
    assign o_out.dec_hi        = r_dec_hi;
    assign o_out.dec_mid       = r_dec_mid;
    assign o_out.dec_lo        = r_dec_lo;
    assign o_out.syndrome      = r_syndrome;
    assign o_out.corrected     = r_corrected;
    assign o_out.uncorrectable = r_uncorrectable;
    assign o_out.erased        = r_erased;
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hamming (29,24) SEC codec testbench
// Sends directed and random encode/decode transactions through the request
// channel and checks every result against a bit-level predictor. Both
// channels idle at random, and the sender drains the block mid-run.
// ---------------------------------------------------------------------------
module testbench;
    import hm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1030;

    typedef struct packed {
        logic        action;
        logic [23:0] data;
        logic [31:0] word;
        bit          drain_first;
    } t_codec_req;

    typedef struct packed {
        logic [31:0] code;
        logic [7:0]  hi;
        logic [7:0]  mid;
        logic [7:0]  lo;
        logic [4:0]  syn;
        logic        fix;
        logic        bad;
        logic        erased;
    } t_codec_res;

    logic clk;
    logic rst_n;

    hm_in_if  req_ch ();
    hm_out_if rsp_ch ();

    hamming_29_24_sec_codec u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    t_codec_req  pending_q[$];
    t_codec_res  expected_q[$];
    t_codec_req  cur_req;
    logic        req_taken = 1'b0;
    logic        rsp_taken = 1'b0;
    int unsigned req_gap   = 0;
    int unsigned req_sent  = 0;
    int unsigned rsp_stall = 0;
    int unsigned rsp_seen  = 0;
    int unsigned cycle_cnt = 0;
    int          err_cnt   = 0;

    // XOR of the Hamming positions of all set bits; bits 31..29 do not count
    function automatic logic [4:0] check_syndrome(logic [31:0] w);
        logic [4:0] s;
        s = '0;
        for (int p = 1; p <= int'(CODE_LEN); p++)
            if (w[int'(CODE_LEN) - p]) s ^= 5'(p);
        return s;
    endfunction

    // data fills the non-power-of-two positions 3..29 from its top bit down
    function automatic logic [31:0] hamming_encode(logic [23:0] data);
        logic [31:0] w;
        logic [4:0]  s;
        int          k;
        w = '0;
        k = 23;
        for (int p = 1; p <= int'(CODE_LEN); p++)
            if ((p & (p - 1)) != 0) begin
                w[int'(CODE_LEN) - p] = data[k];
                k--;
            end
        s = check_syndrome(w);
        for (int j = 0; j < 5; j++) w[int'(CODE_LEN) - (1 << j)] = s[j];
        return w;
    endfunction

    function automatic logic [23:0] hamming_extract(logic [31:0] w);
        logic [23:0] data;
        int          k;
        data = '0;
        k = 23;
        for (int p = 1; p <= int'(CODE_LEN); p++)
            if ((p & (p - 1)) != 0) begin
                data[k] = w[int'(CODE_LEN) - p];
                k--;
            end
        return data;
    endfunction

    function automatic t_codec_res codec_predict(logic act, logic [23:0] data,
                                                 logic [31:0] word);
        t_codec_res  e;
        logic [31:0] w;
        e = '0;
        if (act == ACT_ENCODE) begin
            e.code = hamming_encode(data);
        end else begin
            w = word;
            e.erased = |(w & TOP_MASK);
            e.syn = check_syndrome(w);
            if (e.syn >= 5'd1 && e.syn <= CODE_LEN) begin
                w[int'(CODE_LEN) - int'(e.syn)] = ~w[int'(CODE_LEN) - int'(e.syn)];
                e.fix = 1'b1;
            end else if (e.syn > CODE_LEN) begin
                e.bad = 1'b1;
            end
            {e.hi, e.mid, e.lo} = hamming_extract(w);
        end
        return e;
    endfunction

    function automatic logic [31:0] flip_pos(logic [31:0] w, int p);
        return w ^ (32'd1 << (int'(CODE_LEN) - p));
    endfunction

    // every fourth stretch of 50 transactions runs without idle cycles
    function automatic int unsigned idle_draw(int unsigned n);
        return ((n / 50) % 4 == 3) ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic queue_req(logic act, logic [23:0] data, logic [31:0] word,
                             bit drain);
        t_codec_req r;
        r.action = act;
        r.data = data;
        r.word = word;
        r.drain_first = drain;
        pending_q.push_back(r);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
        err_cnt++;
    endtask

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // request driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req_ch.valid || req_taken) begin
                if (req_gap > 0) begin
                    req_ch.valid <= 1'b0;
                    req_gap <= req_gap - 1;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].drain_first && expected_q.size() != 0)) begin
                    cur_req = pending_q.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= cur_req.action;
                    req_ch.byte_hi     <= cur_req.data[23:16];
                    req_ch.byte_mid    <= cur_req.data[15:8];
                    req_ch.byte_lo     <= cur_req.data[7:0];
                    req_ch.stored_word <= cur_req.word;
                    req_gap <= idle_draw(req_sent);
                    req_sent <= req_sent + 1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result ready driver
    always @(negedge clk) begin
        int unsigned n;
        if (rst_n) begin
            if (rsp_taken) begin
                n = idle_draw(rsp_seen);
                rsp_seen <= rsp_seen + 1;
                rsp_stall <= n;
                rsp_ch.ready <= (n == 0);
            end else if (rsp_stall > 0) begin
                rsp_stall <= rsp_stall - 1;
                rsp_ch.ready <= (rsp_stall == 1);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_codec_res want;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        rsp_taken <= rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", rsp_ch.code_out, 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (rsp_ch.code_out !== want.code)
                    report_mismatch("code_out", rsp_ch.code_out, want.code);
                if (rsp_ch.dec_hi !== want.hi)
                    report_mismatch("dec_hi", 32'(rsp_ch.dec_hi), 32'(want.hi));
                if (rsp_ch.dec_mid !== want.mid)
                    report_mismatch("dec_mid", 32'(rsp_ch.dec_mid), 32'(want.mid));
                if (rsp_ch.dec_lo !== want.lo)
                    report_mismatch("dec_lo", 32'(rsp_ch.dec_lo), 32'(want.lo));
                if (rsp_ch.syndrome !== want.syn)
                    report_mismatch("syndrome", 32'(rsp_ch.syndrome), 32'(want.syn));
                if (rsp_ch.corrected !== want.fix)
                    report_mismatch("corrected", 32'(rsp_ch.corrected), 32'(want.fix));
                if (rsp_ch.uncorrectable !== want.bad)
                    report_mismatch("uncorrectable", 32'(rsp_ch.uncorrectable),
                                    32'(want.bad));
                if (rsp_ch.erased !== want.erased)
                    report_mismatch("erased", 32'(rsp_ch.erased), 32'(want.erased));
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
            expected_q.push_back(codec_predict(req_ch.action,
                {req_ch.byte_hi, req_ch.byte_mid, req_ch.byte_lo}, req_ch.stored_word));
    end

    initial begin
        logic [31:0] cw;
        logic [23:0] d;
        int          kind;
        int          p1;
        int          p2;

        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_ENCODE;
        req_ch.byte_hi = '0;
        req_ch.byte_mid = '0;
        req_ch.byte_lo = '0;
        req_ch.stored_word = '0;
        rsp_ch.ready = 1'b0;

        queue_req(ACT_ENCODE, 24'h000000, 32'h0000_0000, 1'b0);
        queue_req(ACT_ENCODE, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        queue_req(ACT_ENCODE, 24'h800001, 32'h0000_0000, 1'b0);
        queue_req(ACT_ENCODE, 24'h5AA53C, 32'h0000_0000, 1'b0);
        cw = hamming_encode(24'hFFFFFF);
        queue_req(ACT_DECODE, 24'h000000, cw, 1'b0);
        queue_req(ACT_DECODE, 24'hFFFFFF, flip_pos(cw, 1), 1'b0);
        queue_req(ACT_DECODE, 24'h000000, flip_pos(cw, 29), 1'b0);
        queue_req(ACT_DECODE, 24'h000000, flip_pos(cw, 16), 1'b0);
        queue_req(ACT_DECODE, 24'h000000, flip_pos(cw, 3), 1'b0);
        queue_req(ACT_DECODE, 24'h000000, flip_pos(cw, 2), 1'b0);
        cw = hamming_encode(24'h5AA53C);
        // double errors landing on syndromes past the last position
        queue_req(ACT_DECODE, 24'h000000, flip_pos(flip_pos(cw, 16), 14), 1'b0);
        queue_req(ACT_DECODE, 24'h000000, flip_pos(flip_pos(cw, 16), 15), 1'b0);
        // erased words, then an all-zero word and a clean code word
        queue_req(ACT_DECODE, 24'h000000, cw | TOP_MASK, 1'b0);
        queue_req(ACT_DECODE, 24'h000000, flip_pos(cw | 32'h2000_0000, 8), 1'b0);
        queue_req(ACT_DECODE, 24'h000000, cw ^ 32'h4000_0000, 1'b0);
        queue_req(ACT_DECODE, 24'h000000, 32'hFFFF_FFFF, 1'b0);
        queue_req(ACT_DECODE, 24'h000000, 32'h0000_0000, 1'b0);
        queue_req(ACT_DECODE, 24'h000000, hamming_encode(24'h800001), 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            d = 24'($urandom);
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                queue_req(ACT_ENCODE, d, $urandom, i == 0 || i == RANDOM_ITEMS / 2);
            end else begin
                if (kind < 17) begin
                    cw = hamming_encode(d);
                    case ($urandom_range(0, 3))
                        1, 2: cw = flip_pos(cw, $urandom_range(1, 29));
                        3: begin
                            p1 = $urandom_range(1, 29);
                            p2 = $urandom_range(1, 28);
                            if (p2 >= p1) p2++;
                            cw = flip_pos(flip_pos(cw, p1), p2);
                        end
                        default: ;
                    endcase
                    if ($urandom_range(0, 7) == 0) cw[31:29] = 3'($urandom_range(1, 7));
                end else begin
                    cw = $urandom;
                end
                queue_req(ACT_DECODE, 24'($urandom), cw,
                          i == 0 || i == RANDOM_ITEMS / 2);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_ch.valid) @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: hamming_29_24_sec_codec.f
+incdir+rtl
rtl/hm_pkg.sv
rtl/hm_if.sv
rtl/hm_chk_stage.sv
rtl/hm_fix_stage.sv
rtl/hm_out_stage.sv
rtl/hamming_29_24_sec_codec.sv
bench/testbench.sv
